// ===== sv/slt_pkg.sv =====
// shared types and constants for the sorted list table
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        REQ_SEARCH = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
    } slt_ctrl_t;

endpackage

// ===== sv/slt_cell.sv =====
// one cell of the sorted chain: holds one entry and shifts with its neighbors
module slt_cell
    import slt_pkg::*;
(
    input  logic                    clk,
    input  slt_ctrl_t               ctrl,
    input  logic                    occ,
    input  logic                    prev_lt,
    input  logic signed [VAL_W-1:0] prev_entry,
    input  logic signed [VAL_W-1:0] next_entry,
    output logic                    lt,
    output logic                    hit,
    output logic signed [VAL_W-1:0] entry
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    boundary;

    // compare against the broadcast value
    assign lt       = occ & (entry_reg < ctrl.value);
    assign boundary = ~lt & prev_lt;
    assign hit      = boundary & occ & (entry_reg == ctrl.value);
    assign entry    = entry_reg;

    // insert opens a gap at the boundary, remove closes one from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !lt)
        begin
            entry_next = prev_lt ? ctrl.value : prev_entry;
        end
        else if (ctrl.rem && !lt)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/sorted_list_table_unit.sv =====
// sorted list table: a row of compare-and-shift cells with a shared entry count
// latency: the result strobe done is high in the cycle after start is taken
// throughput: one request per cycle; busy is held low, every cell compares and
// shifts in the same cycle, limited by the broadcast compare and the hit reduction
// reset: rst_n clears the entry count and the result strobe; entry contents are
// left as they are and only positions below the count are ever read
module sorted_list_table_unit
    import slt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              req_type,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic                    found,
    output logic [1:0]              status,
    output logic [CNT_OUT_W-1:0]    count,
    output logic                    empty_res
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic                    found_reg;
    logic                    found_next;
    status_t                 status_reg;
    status_t                 status_next;

    logic                    accept;
    req_t                    req;
    logic                    full;
    logic                    any_hit;
    slt_ctrl_t               ctrl;

    logic [CAPACITY-1:0]     occ;
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     hit_vec;
    logic signed [VAL_W-1:0] entry_vec [CAPACITY];

    // request decode
    assign busy    = 1'b0;
    assign accept  = start & ~busy;
    assign req     = req_t'(req_type);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign any_hit = |hit_vec;

    assign ctrl.ins   = accept && (req == REQ_INSERT) && !full;
    assign ctrl.rem   = accept && (req == REQ_REMOVE) && any_hit;
    assign ctrl.value = value;

    // chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                slt_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[gi]),
                    .prev_lt    (1'b1),
                    .prev_entry (value),
                    .next_entry (entry_vec[gi+1]),
                    .lt         (lt_vec[gi]),
                    .hit        (hit_vec[gi]),
                    .entry      (entry_vec[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                slt_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[gi]),
                    .prev_lt    (lt_vec[gi-1]),
                    .prev_entry (entry_vec[gi-1]),
                    .next_entry (entry_vec[gi]),
                    .lt         (lt_vec[gi]),
                    .hit        (hit_vec[gi]),
                    .entry      (entry_vec[gi])
                );
            end
            else
            begin : g_mid
                slt_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occ        (occ[gi]),
                    .prev_lt    (lt_vec[gi-1]),
                    .prev_entry (entry_vec[gi-1]),
                    .next_entry (entry_vec[gi+1]),
                    .lt         (lt_vec[gi]),
                    .hit        (hit_vec[gi]),
                    .entry      (entry_vec[gi])
                );
            end
        end
    endgenerate

    // next count and result fields
    always_comb
    begin
        count_next  = count_reg;
        found_next  = 1'b0;
        status_next = ST_OK;
        unique case (req)
            REQ_SEARCH:
            begin
                found_next = any_hit;
            end
            REQ_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            REQ_REMOVE:
            begin
                if (any_hit)
                begin
                    found_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // result transfer
    assign done      = done_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign count     = CNT_OUT_W'(count_reg);
    assign empty_res = (count_reg == '0);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result strobe after transfer");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_FULL) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found_reg) |-> (status_reg == ST_OK))
        else $error("found with error status");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req == REQ_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

endmodule

// ===== verif/sorted_list_table_unit_test.sv =====
// self-checking testbench for the sorted list table unit
`timescale 1ns / 1ps

module sorted_list_table_unit_test;
    import slt_pkg::*;

    // one result of a request, as seen on the result ports
    typedef struct packed {
        logic                 found;
        status_t              status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_res;
    } outcome_t;

    // one row of the directed stimulus
    typedef struct {
        req_t        req;
        logic [31:0] val;
        int          reps;
        bit          typed;
        outcome_t    want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
    logic                    done;
    logic                    found;
    logic [1:0]              status;
    logic [CNT_OUT_W-1:0]    count;
    logic                    empty_res;

    // predicted contents of the table
    logic signed [VAL_W-1:0] sorted_vals [CAPACITY];
    int                      n_vals;

    outcome_t    pending_outcomes [$];
    stim_row_t   directed_rows [$];
    int          mismatches;
    logic [31:0] value_pool [8];

    sorted_list_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .value     (value),
        .done      (done),
        .found     (found),
        .status    (status),
        .count     (count),
        .empty_res (empty_res)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // applies one request to the predicted table and returns its outcome
    function automatic outcome_t update_sorted_list(req_t r, logic signed [VAL_W-1:0] v);
        outcome_t res;
        int       pos;
        bit       hit;
        res = '{1'b0, ST_OK, '0, 1'b0};
        pos = 0;
        while (pos < n_vals && sorted_vals[pos] < v)
            pos++;
        hit = (pos < n_vals) && (sorted_vals[pos] == v);
        case (r)
            REQ_SEARCH:
                res.found = hit;
            REQ_INSERT:
                if (n_vals >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = n_vals; i > pos; i--)
                        sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[pos] = v;
                    n_vals++;
                end
            REQ_REMOVE:
                if (hit)
                begin
                    for (int i = pos; i + 1 < n_vals; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    n_vals--;
                    res.found = 1'b1;
                end
                else
                    res.status = ST_NOTFOUND;
            default:
                n_vals = 0;
        endcase
        res.count     = n_vals[CNT_OUT_W-1:0];
        res.empty_res = (n_vals == 0);
        return res;
    endfunction

    // drives one request and waits for its transfer
    task automatic issue_request(req_t r, logic [31:0] v, bit allow_idle, bit typed,
                                 outcome_t want);
        outcome_t predicted;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= r;
        value    <= v;
        do
            @(posedge clk);
        while (busy);
        predicted = update_sorted_list(r, v);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // sender stops until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // mostly values that are likely to hit, sometimes fully random ones
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return value_pool[$urandom_range(0, 7)];
        else if (sel < 65 && n_vals > 0)
            return sorted_vals[$urandom_range(0, n_vals - 1)];
        else
            return $urandom;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d status=%0d count=%0d empty=%0d",
                             found, status, count, empty_res);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (found !== want.found || status !== want.status ||
                    count !== want.count || empty_res !== want.empty_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected found=%0d status=%0d count=%0d empty=%0d",
                                 want.found, want.status, want.count, want.empty_res);
                        $display("          got found=%0d status=%0d count=%0d empty=%0d",
                                 found, status, count, empty_res);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        outcome_t   none;
        int         grow;
        int         sel;
        req_t       r;
        mismatches = 0;
        n_vals     = 0;
        none       = '{1'b0, ST_OK, '0, 1'b0};
        value_pool = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_002A};
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_SEARCH;
        value    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, full, clear
        directed_rows = '{
            '{REQ_SEARCH, 32'h0000_0000,  1, 1'b1, '{1'b0, ST_OK,       5'd0,  1'b1}},
            '{REQ_REMOVE, 32'h0000_0005,  1, 1'b1, '{1'b0, ST_NOTFOUND, 5'd0,  1'b1}},
            '{REQ_INSERT, 32'h7FFF_FFFF,  1, 1'b1, '{1'b0, ST_OK,       5'd1,  1'b0}},
            '{REQ_INSERT, 32'h8000_0000,  1, 1'b1, '{1'b0, ST_OK,       5'd2,  1'b0}},
            '{REQ_INSERT, 32'h0000_0000,  1, 1'b1, '{1'b0, ST_OK,       5'd3,  1'b0}},
            '{REQ_INSERT, 32'hFFFF_FFFF,  1, 1'b1, '{1'b0, ST_OK,       5'd4,  1'b0}},
            '{REQ_INSERT, 32'h0000_0000,  1, 1'b1, '{1'b0, ST_OK,       5'd5,  1'b0}},
            '{REQ_SEARCH, 32'h8000_0000,  1, 1'b1, '{1'b1, ST_OK,       5'd5,  1'b0}},
            '{REQ_SEARCH, 32'h7FFF_FFFF,  1, 1'b1, '{1'b1, ST_OK,       5'd5,  1'b0}},
            '{REQ_SEARCH, 32'h0000_0001,  1, 1'b1, '{1'b0, ST_OK,       5'd5,  1'b0}},
            '{REQ_REMOVE, 32'h0000_0000,  1, 1'b1, '{1'b1, ST_OK,       5'd4,  1'b0}},
            '{REQ_REMOVE, 32'h0000_0000,  1, 1'b1, '{1'b1, ST_OK,       5'd3,  1'b0}},
            '{REQ_REMOVE, 32'h0000_0000,  1, 1'b1, '{1'b0, ST_NOTFOUND, 5'd3,  1'b0}},
            '{REQ_INSERT, 32'h5555_5555,  1, 1'b0, none},
            '{REQ_INSERT, 32'hAAAA_AAAA,  1, 1'b0, none},
            '{REQ_INSERT, 32'h1234_5678, 11, 1'b0, none},
            '{REQ_INSERT, 32'h0000_0001,  1, 1'b1, '{1'b0, ST_FULL,     5'd16, 1'b0}},
            '{REQ_SEARCH, 32'hAAAA_AAAA,  1, 1'b0, none},
            '{REQ_CLEAR,  32'hFFFF_FFFF,  1, 1'b1, '{1'b0, ST_OK,       5'd0,  1'b1}},
            '{REQ_REMOVE, 32'h7FFF_FFFF,  1, 1'b1, '{1'b0, ST_NOTFOUND, 5'd0,  1'b1}}
        };
        foreach (directed_rows[i])
            for (int k = 0; k < directed_rows[i].reps; k++)
                issue_request(directed_rows[i].req, directed_rows[i].val + k * 32'h0BAD_F00D,
                              1'b1, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // random: growing and shrinking phases, picked at random every 40 requests, so the
        // table swings between empty and full
        grow = 1;
        for (int n = 0; n < 500; n++)
        begin
            if (n % 40 == 0)
                grow = $urandom_range(0, 1);
            if (n == 250)
                drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 2)
                r = REQ_CLEAR;
            else if (sel < (grow ? 62 : 22))
                r = REQ_INSERT;
            else if (sel < (grow ? 80 : 72))
                r = REQ_REMOVE;
            else
                r = REQ_SEARCH;
            issue_request(r, pick_value(), n < 420, 1'b0, none);
        end
        drain_results();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("sorted_list_table_unit verification clean");
        else
            $display("sorted_list_table_unit verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("sorted_list_table_unit verification failed");
        $finish;
    end

endmodule
